// ----- hdl/mhsd_pkg.sv -----
// Package for the max-hold stencil diffuser: sizes, types, the divide-by-five constant
// and the dimension clamp.
// Depends on nothing; every other file in hdl/ imports it.
package mhsd_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_HEIGHT     = 1024;
	localparam int PIXEL_BITS     = 24;
	localparam int DIM_BITS       = 11;
	localparam int CFG_IDX_BITS   = 1;
	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int ROW_BITS       = $clog2(MAX_HEIGHT);

	// five-point mean: four-term partial sum, five-term sum, reciprocal multiply
	localparam int STENCIL_POINTS = 5;
	localparam int PART_BITS      = PIXEL_BITS + 2;
	localparam int SUM_BITS       = PIXEL_BITS + 3;
	localparam int RECIP_SHIFT    = SUM_BITS + 3;
	localparam int RECIP_BITS     = RECIP_SHIFT - 2;
	localparam int PROD_BITS      = SUM_BITS + RECIP_BITS;
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(
		((64'd1 << RECIP_SHIFT) + 64'(STENCIL_POINTS) - 64'd1) / 64'(STENCIL_POINTS));

	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS      = QPTR_BITS + 1;

	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef logic [COL_BITS-1:0]   col_t;
	typedef logic [ROW_BITS-1:0]   row_t;
	typedef logic [DIM_BITS-1:0]   dim_t;

	localparam dim_t DIM_RESET  = dim_t'(1000);
	localparam dim_t DIM_MIN    = dim_t'(2);
	localparam dim_t WIDTH_MAX  = dim_t'(MAX_WIDTH);
	localparam dim_t HEIGHT_MAX = dim_t'(MAX_HEIGHT);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_e;

	// what the front decides about one pixel
	typedef struct packed {
		logic has_res;    // not in the first row: completes the pixel above
		logic last_row;   // second result: the pixel itself, passed through
		logic interior;   // not the last column: stencil applies
		logic up_zero;    // upper neighbour lies outside the frame
		logic left_zero;  // left neighbour lies outside the frame
		logic frame_end;  // final pixel of the frame
	} item_flags_t;

	typedef struct packed {
		pix_t        pix;
		col_t        col;
		item_flags_t flags;
	} queue_item_t;

	function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
		dim_t r;
		priority if (v < DIM_MIN) begin
			r = DIM_MIN;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- hdl/mhsd_front.sv -----
// Front end: frame size registers, raster position counters and per-pixel classification.
// Depends on mhsd_pkg; feeds mhsd_queue.
module mhsd_front
	import mhsd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  dim_t                    cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  pix_t                    pixel_value,
	input  logic                    q_ready,
	output logic                    push,
	output queue_item_t             push_item
);

	dim_t        width_q;
	dim_t        height_q;
	col_t        col_q;
	row_t        row_q;
	dim_t        w_eff;
	dim_t        h_eff;
	logic        last_col;
	logic        last_row;
	item_flags_t flags;

	always_comb begin
		w_eff    = clamp_dim(width_q, WIDTH_MAX);
		h_eff    = clamp_dim(height_q, HEIGHT_MAX);
		last_col = (DIM_BITS'(col_q) == w_eff - dim_t'(1));
		last_row = (DIM_BITS'(row_q) == h_eff - dim_t'(1));

		flags.has_res   = (row_q != '0);
		flags.last_row  = last_row;
		flags.interior  = !last_col;
		flags.up_zero   = (row_q == row_t'(1));
		flags.left_zero = (col_q == '0);
		flags.frame_end = last_row && last_col;

		in_ready  = q_ready;
		push      = in_valid && q_ready;
		push_item = '{pix: pixel_value, col: col_q, flags: flags};
	end

	// any register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + row_t'(1);
			end else begin
				col_q <= col_q + col_t'(1);
			end
		end
	end

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(DIM_BITS'(col_q) < w_eff) && (DIM_BITS'(row_q) < h_eff))
		else $error("raster position outside the frame");

endmodule

// ----- hdl/mhsd_queue.sv -----
// Short queue of classified pixels between front and back end.
// Depends on mhsd_pkg.
module mhsd_queue
	import mhsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  queue_item_t push_item,
	output logic        q_ready,
	output logic        q_valid,
	output queue_item_t q_item,
	input  logic        pop
);

	queue_item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]    wr_ptr_q;
	logic [QPTR_BITS-1:0]    rd_ptr_q;
	logic [QCNT_BITS-1:0]    count_q;

	assign q_ready = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_BITS'(1);
				2'b01:   count_q <= count_q - QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue occupancy beyond depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_BITS'(1)))
		else $error("queue count missed a push");

endmodule

// ----- hdl/mhsd_back.sv -----
// Back end: row stores, five-point mean with max-hold, and the two-deep output register.
// Depends on mhsd_pkg; takes items from mhsd_queue.
module mhsd_back
	import mhsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  queue_item_t q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output pix_t        out_pixel,
	output logic        frame_end,
	output logic        run_last
);

	// row stores: original values of the pending row, results of the row above
	pix_t orig_mem [MAX_WIDTH];
	pix_t upd_mem  [MAX_WIDTH];

	logic                   adv;
	col_t                   col_nx;

	logic                   valid_s1;
	queue_item_t            item_s1;
	pix_t                   center_s1;
	pix_t                   right_s1;
	pix_t                   up_rd_s1;
	logic                   byp_hit_s1;
	pix_t                   byp_pix_s1;
	pix_t                   up_val;
	logic [PART_BITS-1:0]   part;

	logic                   valid_s2;
	pix_t                   pix_s2;
	col_t                   col_s2;
	item_flags_t            flags_s2;
	pix_t                   center_s2;
	logic [PART_BITS-1:0]   part_s2;

	pix_t                   left_q;
	pix_t                   left_val;
	logic [SUM_BITS-1:0]    sum;
	logic [PROD_BITS-1:0]   prod;
	pix_t                   mean;
	pix_t                   result;
	logic                   emit;

	logic                   o_valid_q;
	pix_t                   out_pixel_q;
	logic                   frame_end_q;
	logic                   run_last_q;
	logic                   sec_valid_q;
	pix_t                   sec_pixel_q;
	logic                   sec_frame_end_q;

	// whole pipe moves when the output register can take what leaves s2
	assign adv    = !o_valid_q || (out_ready && !sec_valid_q);
	assign q_pop  = adv && q_valid;
	assign col_nx = q_item.col + col_t'(1);

	// read-before-write: centre sees the previous row's value
	always_ff @(posedge clk) begin
		if (adv) begin
			center_s1 <= orig_mem[q_item.col];
			right_s1  <= orig_mem[col_nx];
		end
		if (q_pop) begin
			orig_mem[q_item.col] <= q_item.pix;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			up_rd_s1 <= upd_mem[q_item.col];
		end
		if (adv && emit) begin
			upd_mem[col_s2] <= result;
		end
	end

	// s1: partial sum of the four terms that do not depend on the previous result
	always_comb begin
		priority if (item_s1.flags.up_zero) begin
			up_val = '0;
		end else if (byp_hit_s1) begin
			up_val = byp_pix_s1;
		end else begin
			up_val = up_rd_s1;
		end
		part = PART_BITS'(center_s1) + PART_BITS'(right_s1)
			+ PART_BITS'(item_s1.pix) + PART_BITS'(up_val);
	end

	// s2: add left result, divide by five, keep the larger of mean and centre (centre in the last column)
	always_comb begin
		left_val = flags_s2.left_zero ? '0 : left_q;
		sum      = SUM_BITS'(part_s2) + SUM_BITS'(left_val);
		prod     = PROD_BITS'(sum) * PROD_BITS'(RECIP);
		mean     = prod[RECIP_SHIFT +: PIXEL_BITS];
		result   = (flags_s2.interior && (mean >= center_s2)) ? mean : center_s2;
		emit     = valid_s2 && flags_s2.has_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			left_q   <= '0;
		end else if (adv) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
			if (emit) begin
				left_q <= result;
			end
		end
	end

	// an upper result still in s2 when its column is read again (two-pixel rows)
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1    <= q_item;
			byp_hit_s1 <= q_valid && emit && (col_s2 == q_item.col);
			byp_pix_s1 <= result;
			pix_s2     <= item_s1.pix;
			col_s2     <= item_s1.col;
			flags_s2   <= item_s1.flags;
			center_s2  <= center_s1;
			part_s2    <= part;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q   <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (adv) begin
			o_valid_q   <= emit;
			sec_valid_q <= emit && flags_s2.last_row;
		end else if (out_ready && sec_valid_q) begin
			sec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pixel_q     <= result;
			frame_end_q     <= 1'b0;
			run_last_q      <= !flags_s2.last_row;
			sec_pixel_q     <= pix_s2;
			sec_frame_end_q <= flags_s2.frame_end;
		end else if (out_ready && sec_valid_q) begin
			out_pixel_q <= sec_pixel_q;
			frame_end_q <= sec_frame_end_q;
			run_last_q  <= 1'b1;
		end
	end

	assign out_valid = o_valid_q;
	assign out_pixel = out_pixel_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

	a_sec_behind_first: assert property (@(posedge clk) disable iff (!arst_n)
		sec_valid_q |-> o_valid_q)
		else $error("second beat pending without a first");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && frame_end_q) |-> run_last_q)
		else $error("frame end on a beat that is not the last of its pixel");

	a_byp_with_item: assert property (@(posedge clk) disable iff (!arst_n)
		byp_hit_s1 |-> valid_s1)
		else $error("bypass hit without an item in s1");

endmodule

// ----- hdl/max_hold_stencil_diffuser_core.sv -----
// Path: a pixel that completes a result passes the queue, the store read, the partial sum and
//   the mean and max-hold; the result then leaves the output register. Results lag one row.
// Throughput: 1 pixel per cycle when unstalled; last row 2 beats per pixel, set by output register.
// Reset: frame 1000 x 1000, position row 0 column 0; row stores are not cleared, since
//   every entry is written before it is used within a frame. A register write restarts it.
// Depends on mhsd_pkg, mhsd_front, mhsd_queue, mhsd_back.
module max_hold_stencil_diffuser_core
	import mhsd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// register write port: 0 frame width, 1 frame height
	input  logic                    cfg_write,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  dim_t                    cfg_data,
	// pixel input, raster order
	input  logic                    in_valid,
	output logic                    in_ready,
	input  pix_t                    pixel_value,
	// diffused pixels
	output logic                    out_valid,
	input  logic                    out_ready,
	output pix_t                    out_pixel,
	output logic                    frame_end,
	output logic                    run_last
);

	// front -> queue
	logic        push;
	queue_item_t push_item;
	logic        q_ready;
	// queue -> back
	logic        q_valid;
	queue_item_t q_item;
	logic        q_pop;

	// Front: holds the frame size, walks the raster position and tags each beat with
	// what the back end must do (emit, pass through, zero neighbours, frame end).
	mhsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_value (pixel_value),
		.q_ready     (q_ready),
		.push        (push),
		.push_item   (push_item)
	);

	// Queue: absorbs the last row, where the back end gives two beats per pixel,
	// and keeps input ready off the output handshake.
	mhsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (q_pop)
	);

	// Back: reads centre, right and upper values from the row stores, forms the
	// five-point mean against the left result, applies max-hold and emits.
	mhsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pixel (out_pixel),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

endmodule

// ----- verif/tb_max_hold_stencil_diffuser_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for max_hold_stencil_diffuser_core. It streams raster-order pixels
// with random gaps and back-pressure, predicts every diffused beat and checks it field by field.
// Depends on mhsd_pkg and the core RTL only.
module tb_max_hold_stencil_diffuser_core;
	import mhsd_pkg::*;

	localparam int   HALF_PERIOD     = 5;
	localparam int   RESET_CYCLES    = 11;
	// margin for beats still in flight after the last expected one
	localparam int   SETTLE_CYCLES   = 8;
	// longest legal quiet stretch is the receiver hold-off plus settling; several times over
	localparam int   QUIET_LIMIT     = 2000;
	localparam int   HOLD_OFF_CYCLES = 150;
	localparam int   RANDOM_PIXELS   = 240;
	// large geometries are only walked part of the way in
	localparam int   RESET_PIXELS    = 24;
	localparam int   WIDE_PIXELS     = 24;
	localparam int   TALL_PIXELS     = 60;
	localparam int   PRINT_LIMIT     = 50;
	localparam int   RESET_DIM       = 1000;
	localparam pix_t PIX_MAX         = '1;

	// one diffused beat as it should leave the core
	typedef struct {
		pix_t pix;
		logic frame_end;
		logic run_last;
	} diffused_beat_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	dim_t                    cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	pix_t                    pixel_value;
	logic                    out_valid;
	logic                    out_ready;
	pix_t                    out_pixel;
	logic                    frame_end;
	logic                    run_last;

	// predictor copy of the frame geometry and the diffusion state
	dim_t        width_reg;
	dim_t        height_reg;
	pix_t        updated_row [MAX_WIDTH];   // results of the row above
	pix_t        arrived_row [MAX_WIDTH];   // raw pixels of the pending row
	pix_t        left_result;
	int unsigned col_pos;
	int unsigned row_pos;
	diffused_beat_t diffused_q [$];         // beats still owed by the core, oldest first

	// traffic shaping, shared with the result sink
	bit tx_gaps_on    = 1'b1;
	bit rx_stalls_on  = 1'b1;
	int rx_hold_cycles = 0;
	int error_count    = 0;

	max_hold_stencil_diffuser_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_pixel   (out_pixel),
		.frame_end   (frame_end),
		.run_last    (run_last)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// register values below 2 act as 2, values above the store size act as the maximum
	function automatic int unsigned dim_in_use(input dim_t v, input int unsigned hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return 32'(v);
	endfunction

	function automatic void restart_frame();
		left_result = '0;
		col_pos     = 0;
		row_pos     = 0;
	endfunction

	// any register write restarts the frame at row 0, column 0
	function automatic void model_register(input cfg_reg_e idx, input dim_t v);
		if (idx == REG_FRAME_WIDTH) begin
			width_reg = v;
		end else begin
			height_reg = v;
		end
		restart_frame();
	endfunction

	// One accepted pixel. It completes the pending pixel above it (none on row 0); on the
	// last row the pixel itself follows straight away, passed through.
	function automatic void model_pixel(input pix_t pix);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		pix_t        centre;
		pix_t        up_val;
		pix_t        left_val;
		pix_t        result;
		logic        on_last_row;
		w = dim_in_use(width_reg, MAX_WIDTH);
		h = dim_in_use(height_reg, MAX_HEIGHT);
		if (row_pos > 0) begin
			centre      = arrived_row[col_pos];
			result      = centre;
			on_last_row = (row_pos == h - 1);
			// last column passes through; elsewhere max-hold of the five-point mean
			if (col_pos < w - 1) begin
				// neighbours outside the frame count as zero
				up_val   = (row_pos == 1) ? '0 : updated_row[col_pos];
				left_val = (col_pos == 0) ? '0 : left_result;
				total    = 32'(left_val) + 32'(arrived_row[col_pos + 1]) + 32'(pix)
					+ 32'(up_val) + 32'(centre);
				if (total / STENCIL_POINTS >= 32'(centre)) begin
					result = pix_t'(total / STENCIL_POINTS);
				end
			end
			updated_row[col_pos] = result;
			left_result          = result;
			diffused_q.push_back(diffused_beat_t'{result, 1'b0, !on_last_row});
			if (on_last_row) begin
				diffused_q.push_back(diffused_beat_t'{pix, col_pos == w - 1, 1'b1});
			end
		end
		arrived_row[col_pos] = pix;
		col_pos++;
		if (col_pos >= w) begin
			col_pos     = 0;
			left_result = '0;
			row_pos++;
			if (row_pos >= h) begin
				row_pos = 0;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	// one line per mismatch; the log is capped, the count is not
	task automatic report_mismatch(input string what, input pix_t got, input pix_t want);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		end
	endtask

	// every accepted beat is held against the oldest prediction
	always @(posedge clk) begin : beat_checker
		diffused_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (diffused_q.size() == 0) begin
				report_mismatch("beat with nothing owed", out_pixel, '0);
			end else begin
				want = diffused_q.pop_front();
				if (out_pixel !== want.pix) begin
					report_mismatch("out_pixel", out_pixel, want.pix);
				end
				if (frame_end !== want.frame_end) begin
					report_mismatch("frame_end", pix_t'(frame_end), pix_t'(want.frame_end));
				end
				if (run_last !== want.run_last) begin
					report_mismatch("run_last", pix_t'(run_last), pix_t'(want.run_last));
				end
			end
		end
	end

	// Result sink: a random stall before each beat, or a long hold-off when a test asks for one.
	// The hold-off is counted here so the sender keeps pushing meanwhile.
	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end
			stall = rx_stalls_on ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid && rx_hold_cycles == 0);
		end
	end

	// Watchdog: ends the run once nothing has moved on any port for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offers one pixel after a random gap and returns at the edge that takes it. Valid is
	// only dropped when a gap is drawn, so back-to-back beats keep it high.
	task automatic send_pixel(input pix_t v);
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= v;
		do @(posedge clk); while (!in_ready);
		model_pixel(v);
	endtask

	// biased towards the ends of the range so both sides of the max-hold get exercised
	function automatic pix_t pick_pixel();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return PIX_MAX;
			end
			2: begin
				return pix_t'($urandom_range(0, 15));
			end
			3: begin
				return PIX_MAX - pix_t'($urandom_range(0, 15));
			end
			default: begin
				return pix_t'($urandom());
			end
		endcase
	endfunction

	task automatic send_pixels(input int n);
		repeat (n) send_pixel(pick_pixel());
	endtask

	// sender stops and waits until every owed beat has come back; waits on the clock even when nothing is owed
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (diffused_q.size() != 0);
	endtask

	// Writes go in only when the core is idle: drained, plus time for row-0 pixels that owe
	// no beat but may still be in the pipeline.
	task automatic write_register(input cfg_reg_e idx, input dim_t v);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		model_register(idx, v);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// no register written: 1000-wide frame, so a stretch of row 0 owes no beat at all
	task automatic test_reset_geometry();
		send_pixels(RESET_PIXELS);
		wait_for_results();
	endtask

	// values of 0 and 1 clamp to 2; then the legal minimum written directly
	task automatic test_smallest_frame();
		write_register(REG_FRAME_WIDTH, dim_t'(0));
		write_register(REG_FRAME_HEIGHT, dim_t'(1));
		send_pixel('0);
		send_pixel(PIX_MAX);
		send_pixel(PIX_MAX);
		send_pixel('0);
		write_register(REG_FRAME_WIDTH, dim_t'(2));
		write_register(REG_FRAME_HEIGHT, dim_t'(2));
		send_pixel(PIX_MAX);
		send_pixel('0);
		send_pixel('0);
		send_pixel(PIX_MAX);
		wait_for_results();
	endtask

	// 4x4 frame: full-scale sums, held peaks, zero edges, pass-through column and last row
	task automatic test_stencil_cases();
		pix_t grid [16];
		grid = '{PIX_MAX, '0,      pix_t'(5), PIX_MAX,
		         PIX_MAX, PIX_MAX, pix_t'(4), '0,
		         '0,      pix_t'(1), PIX_MAX, pix_t'(7),
		         PIX_MAX, PIX_MAX, PIX_MAX,   PIX_MAX};
		write_register(REG_FRAME_WIDTH, dim_t'(4));
		write_register(REG_FRAME_HEIGHT, dim_t'(4));
		foreach (grid[k]) begin
			send_pixel(grid[k]);
		end
		wait_for_results();
	endtask

	// two frames back to back with no idling on either side: position wraps to row 0
	task automatic test_frame_wrap();
		write_register(REG_FRAME_WIDTH, dim_t'(3));
		write_register(REG_FRAME_HEIGHT, dim_t'(3));
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		send_pixels(18);
		wait_for_results();
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// widest row the stores hold; only the start of row 0, which owes no beat
	task automatic test_widest_frame();
		write_register(REG_FRAME_WIDTH, dim_t'(MAX_WIDTH));
		write_register(REG_FRAME_HEIGHT, dim_t'(2));
		send_pixels(WIDE_PIXELS);
		wait_for_results();
	endtask

	// all-ones height clamps to the maximum; narrowest width, a few dozen rows in
	task automatic test_tallest_frame();
		write_register(REG_FRAME_HEIGHT, '1);
		write_register(REG_FRAME_WIDTH, dim_t'(2));
		send_pixels(TALL_PIXELS);
		wait_for_results();
	endtask

	// Sink holds off while the source keeps offering, so the core fills and drops in_ready.
	// Mid-frame the source then pauses until every owed beat is back before finishing.
	task automatic test_back_pressure();
		write_register(REG_FRAME_WIDTH, dim_t'(5));
		write_register(REG_FRAME_HEIGHT, dim_t'(6));
		tx_gaps_on     = 1'b0;
		rx_hold_cycles = HOLD_OFF_CYCLES;
		send_pixels(18);
		wait_for_results();
		tx_gaps_on = 1'b1;
		send_pixels(12);
		wait_for_results();
	endtask

	// Mostly whole frames of random small geometry with random content; now and then a
	// frame is cut short and either restarted by a write or carried on from where it stopped.
	task automatic test_random_frames();
		int sent;
		int n;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			tx_gaps_on   = ($urandom_range(0, 3) != 0);
			rx_stalls_on = ($urandom_range(0, 3) != 0);
			if (sent == 0 || $urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 1) == 1) begin
					write_register(REG_FRAME_WIDTH, dim_t'($urandom_range(0, 12)));
					write_register(REG_FRAME_HEIGHT, dim_t'($urandom_range(0, 7)));
				end else begin
					write_register(REG_FRAME_HEIGHT, dim_t'($urandom_range(0, 7)));
					write_register(REG_FRAME_WIDTH, dim_t'($urandom_range(0, 12)));
				end
			end
			n = dim_in_use(width_reg, MAX_WIDTH) * dim_in_use(height_reg, MAX_HEIGHT);
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, n - 1);
			end
			send_pixels(n);
			sent += n;
			if ($urandom_range(0, 5) == 0) begin
				wait_for_results();
			end
		end
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		wait_for_results();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n      <= 1'b0;
		cfg_write   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		pixel_value <= '0;
		width_reg  = dim_t'(RESET_DIM);
		height_reg = dim_t'(RESET_DIM);
		restart_frame();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_smallest_frame();
		test_stencil_cases();
		test_frame_wrap();
		test_back_pressure();
		test_widest_frame();
		test_tallest_frame();
		test_random_frames();

		// nothing owed now; give any stray beat time to show up
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/mhsd_pkg.sv
hdl/mhsd_front.sv
hdl/mhsd_queue.sv
hdl/mhsd_back.sv
hdl/max_hold_stencil_diffuser_core.sv
verif/tb_max_hold_stencil_diffuser_core.sv
